/* hw/rtl/fatcca_pkg.sv */
// Shared types, codes and constants of the FAT12 cluster chain allocator.
package fatcca_pkg;

  localparam int CLUSTER_W = 12;
  localparam int CFG_W = 13;
  localparam int OPCODE_W = 3;
  localparam int TABLE_ENTRIES_DEFAULT = 4096;

  localparam logic [CFG_W-1:0] VALID_ENTRIES_RESET = 13'd2849;
  localparam logic [CLUSTER_W-1:0] END_MARK = 12'hFFF;

  localparam logic [OPCODE_W-1:0] OP_FIND_FREE = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_CHAIN_STEP = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_CHAIN_END = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_READ_ENTRY = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_WRITE_ENTRY = 3'd4;

  typedef struct packed {
    logic [OPCODE_W-1:0]  opcode;
    logic [CLUSTER_W-1:0] cluster;
    logic [CLUSTER_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] result_cluster;
    logic                 status;
  } res_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_LINK,
    WR_END,
    WR_VALUE
  } wr_sel_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_FOUND,
    RES_FAIL,
    RES_END,
    RES_READ
  } res_sel_t;

  typedef struct packed {
    logic     load_req;
    logic     clear_step;
    logic     scan_start;
    logic     scan_step;
    logic     rd_entry;
    wr_sel_t  wr_sel;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                clear_last;
    logic                scan_hit;
    logic                scan_done;
    logic                out_busy;
  } dp_status_t;

endpackage

/* hw/rtl/fatcca_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fatcca_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/fatcca_dp.sv */
// Datapath of the allocator: request registers, table memory, scan pointers and result register.
module fatcca_dp #(
  parameter int TABLE_ENTRIES = fatcca_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fatcca_pkg::req_t            req,
  input  logic                        cfg_we,
  input  logic [fatcca_pkg::CFG_W-1:0] cfg_data,
  input  fatcca_pkg::dp_cmd_t         cmd,
  output fatcca_pkg::dp_status_t      st,
  output logic                        res_valid,
  input  logic                        res_ready,
  output fatcca_pkg::res_t            res
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [fatcca_pkg::CFG_W-1:0] TABLE_LIM = fatcca_pkg::CFG_W'(TABLE_ENTRIES);
  localparam logic [AW-1:0] CLEAR_LAST = AW'(TABLE_ENTRIES - 1);

  logic [fatcca_pkg::OPCODE_W-1:0]  op;
  logic [fatcca_pkg::CLUSTER_W-1:0] cl;
  logic [fatcca_pkg::CLUSTER_W-1:0] val;
  logic [fatcca_pkg::CFG_W-1:0]     valid_entries;
  logic [AW-1:0]                    clr_addr;
  logic [fatcca_pkg::CFG_W-1:0]     scan_addr;
  logic [fatcca_pkg::CFG_W-1:0]     chk_addr;
  logic                             chk_valid;
  logic [fatcca_pkg::CLUSTER_W-1:0] pend_cluster;
  logic                             pend_status;
  logic                             out_valid;
  fatcca_pkg::res_t                 out_res;

  logic [fatcca_pkg::CFG_W-1:0]     lim;
  logic                             scan_live;
  logic                             cl_in_table;
  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [fatcca_pkg::CLUSTER_W-1:0] ram_wdata;
  logic [AW-1:0]                    ram_raddr;
  logic [fatcca_pkg::CLUSTER_W-1:0] ram_rdata;

  assign lim = (valid_entries < TABLE_LIM) ? valid_entries : TABLE_LIM;
  assign scan_live = scan_addr < lim;
  assign cl_in_table = {1'b0, cl} < TABLE_LIM;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = cl[AW-1:0];
    ram_wdata = '0;
    unique case (cmd.wr_sel)
      fatcca_pkg::WR_NONE: begin
        ram_we = 1'b0;
      end
      fatcca_pkg::WR_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_addr;
      end
      fatcca_pkg::WR_LINK: begin
        ram_we = cl_in_table;
        ram_wdata = chk_addr[fatcca_pkg::CLUSTER_W-1:0];
      end
      fatcca_pkg::WR_END: begin
        ram_we = cl_in_table;
        ram_wdata = fatcca_pkg::END_MARK;
      end
      fatcca_pkg::WR_VALUE: begin
        ram_we = cl_in_table;
        ram_wdata = val;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_raddr = cmd.rd_entry ? cl[AW-1:0] : scan_addr[AW-1:0];

  fatcca_ram #(
    .WIDTH(fatcca_pkg::CLUSTER_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_entries <= fatcca_pkg::VALID_ENTRIES_RESET;
      clr_addr <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        valid_entries <= cfg_data;
      end
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.scan_start) begin
        chk_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        chk_valid <= scan_live;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (res_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op <= req.opcode;
      cl <= req.cluster;
      val <= req.entry_value;
    end
    if (cmd.scan_start) begin
      scan_addr <= {1'b0, cl} + fatcca_pkg::CFG_W'(1);
    end else if (cmd.scan_step && scan_live) begin
      scan_addr <= scan_addr + fatcca_pkg::CFG_W'(1);
      chk_addr <= scan_addr;
    end
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        fatcca_pkg::RES_ZERO: begin
          pend_cluster <= '0;
          pend_status <= 1'b0;
        end
        fatcca_pkg::RES_FOUND: begin
          pend_cluster <= chk_addr[fatcca_pkg::CLUSTER_W-1:0];
          pend_status <= 1'b0;
        end
        fatcca_pkg::RES_FAIL: begin
          pend_cluster <= '0;
          pend_status <= 1'b1;
        end
        fatcca_pkg::RES_END: begin
          pend_cluster <= fatcca_pkg::END_MARK;
          pend_status <= 1'b0;
        end
        fatcca_pkg::RES_READ: begin
          pend_cluster <= cl_in_table ? ram_rdata : '0;
          pend_status <= 1'b0;
        end
        default: begin
          pend_cluster <= '0;
          pend_status <= 1'b0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_res.result_cluster <= pend_cluster;
      out_res.status <= pend_status;
    end
  end

  assign st.op = op;
  assign st.clear_last = clr_addr == CLEAR_LAST;
  assign st.scan_hit = chk_valid && (ram_rdata == '0);
  assign st.scan_done = !chk_valid && !scan_live;
  assign st.out_busy = out_valid && !res_ready;

  assign res_valid = out_valid;
  assign res = out_res;

endmodule

/* hw/rtl/fatcca_ctrl.sv */
// Controller state machine of the allocator: clearing pass, decode, scan, read and result hand-off.
module fatcca_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  fatcca_pkg::dp_status_t st,
  output fatcca_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_READ,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    req_ready = 1'b0;
    cmd = '0;
    cmd.wr_sel = fatcca_pkg::WR_NONE;
    cmd.res_sel = fatcca_pkg::RES_ZERO;
    unique case (state)
      S_CLEAR: begin
        cmd.wr_sel = fatcca_pkg::WR_CLEAR;
        cmd.clear_step = 1'b1;
        if (st.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.op)
          fatcca_pkg::OP_FIND_FREE, fatcca_pkg::OP_CHAIN_STEP: begin
            cmd.scan_start = 1'b1;
            state_next = S_SCAN;
          end
          fatcca_pkg::OP_CHAIN_END: begin
            cmd.wr_sel = fatcca_pkg::WR_END;
            cmd.res_load = 1'b1;
            cmd.res_sel = fatcca_pkg::RES_END;
            state_next = S_FINISH;
          end
          fatcca_pkg::OP_READ_ENTRY: begin
            cmd.rd_entry = 1'b1;
            state_next = S_READ;
          end
          fatcca_pkg::OP_WRITE_ENTRY: begin
            cmd.wr_sel = fatcca_pkg::WR_VALUE;
            cmd.res_load = 1'b1;
            state_next = S_FINISH;
          end
          default: begin
            cmd.res_load = 1'b1;
            state_next = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        priority if (st.scan_hit) begin
          if (st.op == fatcca_pkg::OP_CHAIN_STEP) begin
            cmd.wr_sel = fatcca_pkg::WR_LINK;
          end
          cmd.res_load = 1'b1;
          cmd.res_sel = fatcca_pkg::RES_FOUND;
          state_next = S_FINISH;
        end else if (st.scan_done) begin
          cmd.res_load = 1'b1;
          cmd.res_sel = fatcca_pkg::RES_FAIL;
          state_next = S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_READ: begin
        cmd.res_load = 1'b1;
        cmd.res_sel = fatcca_pkg::RES_READ;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/fat12_cluster_chain_allocator.sv */
// Top level of the FAT12 cluster chain allocator.
// The block holds a table of TABLE_ENTRIES twelve-bit FAT entries and serves one request at a
// time. After reset it clears every table entry, during which req_ready stays low; cfg_we
// writes are taken at any time. Chain end, write entry and unused opcodes pass from decode to
// finish, read entry from decode through a read state to finish. Find free and chain step scan
// from the entry after the given cluster up to the valid-entry limit for a free entry, reading
// one entry per cycle through the single read port of the table memory. A finished result waits
// in an output register until it is taken, and the next request may be accepted meanwhile.
module fat12_cluster_chain_allocator #(
  parameter int TABLE_ENTRIES = fatcca_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  fatcca_pkg::req_t             req,
  output logic                         res_valid,
  input  logic                         res_ready,
  output fatcca_pkg::res_t             res,
  input  logic                         cfg_we,
  input  logic [fatcca_pkg::CFG_W-1:0] cfg_data
);

  fatcca_pkg::dp_cmd_t    cmd;
  fatcca_pkg::dp_status_t st;

  fatcca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  fatcca_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

/* hw/rtl/fatcca_checker.sv */
// Port-level checker of the allocator and its bind to the top level.
module fatcca_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input fatcca_pkg::req_t req,
  input logic             res_valid,
  input logic             res_ready,
  input fatcca_pkg::res_t res
);

  // A result that is not taken stays in place.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // A request that is not taken stays in place.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while stalled");

  // A failed scan always reports cluster zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status |-> res.result_cluster == '0)
    else $error("no-free status with nonzero cluster");

  // Only one request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in work");

  // Reset empties the output and starts the clearing pass.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !res_valid && !req_ready)
    else $error("block not quiet after reset");

endmodule

bind fat12_cluster_chain_allocator fatcca_checker u_fatcca_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

/* tb/fat12_cluster_chain_allocator_tb.sv */
// Self-checking testbench for the FAT12 cluster chain allocator: directed and random requests.
module fat12_cluster_chain_allocator_tb;

  localparam int TBL_ENTRIES = fatcca_pkg::TABLE_ENTRIES_DEFAULT;
  localparam int WATCHDOG_LIMIT = 5 * (TBL_ENTRIES + 16);
  localparam int IDLE_PCT = 9;
  localparam logic ST_NO_FREE = 1'b1;
  localparam logic [fatcca_pkg::OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [fatcca_pkg::OPCODE_W-1:0] OP_UNUSED_LAST = 3'd7;

  class fat_chain_scoreboard;
    logic [fatcca_pkg::CLUSTER_W-1:0] shadow_fat [TBL_ENTRIES];
    int unsigned search_lim;
    fatcca_pkg::res_t awaited_results [$];
    int errors;
    int results_seen;
    int failed_scans;
    int op_seen [8];

    function new();
      foreach (shadow_fat[i]) shadow_fat[i] = '0;
      foreach (op_seen[i]) op_seen[i] = 0;
      search_lim = fatcca_pkg::VALID_ENTRIES_RESET;
      errors = 0;
      results_seen = 0;
      failed_scans = 0;
    endfunction

    function void set_valid_entries(logic [fatcca_pkg::CFG_W-1:0] v);
      search_lim = (int'(v) > TBL_ENTRIES) ? TBL_ENTRIES : int'(v);
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function fatcca_pkg::res_t note_request(fatcca_pkg::req_t r);
      fatcca_pkg::res_t o;
      int i;
      int hit;
      o = '0;
      op_seen[r.opcode]++;
      case (r.opcode)
        fatcca_pkg::OP_FIND_FREE, fatcca_pkg::OP_CHAIN_STEP: begin
          hit = -1;
          for (i = int'(r.cluster) + 1; i < int'(search_lim) && hit < 0; i++)
            if (shadow_fat[i] == '0) hit = i;
          if (hit < 0) begin
            o.status = ST_NO_FREE;
            failed_scans++;
          end else begin
            o.result_cluster = hit[fatcca_pkg::CLUSTER_W-1:0];
            if (r.opcode == fatcca_pkg::OP_CHAIN_STEP && int'(r.cluster) < TBL_ENTRIES)
              shadow_fat[r.cluster] = hit[fatcca_pkg::CLUSTER_W-1:0];
          end
        end
        fatcca_pkg::OP_CHAIN_END: begin
          if (int'(r.cluster) < TBL_ENTRIES) shadow_fat[r.cluster] = fatcca_pkg::END_MARK;
          o.result_cluster = fatcca_pkg::END_MARK;
        end
        fatcca_pkg::OP_READ_ENTRY: begin
          if (int'(r.cluster) < TBL_ENTRIES) o.result_cluster = shadow_fat[r.cluster];
        end
        fatcca_pkg::OP_WRITE_ENTRY: begin
          if (int'(r.cluster) < TBL_ENTRIES) shadow_fat[r.cluster] = r.entry_value;
        end
        default: begin
        end
      endcase
      awaited_results.push_back(o);
      return o;
    endfunction

    function void check_result(fatcca_pkg::res_t got);
      fatcca_pkg::res_t want;
      results_seen++;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got cluster %h status %0d",
                 $time, got.result_cluster, got.status);
      end else begin
        want = awaited_results.pop_front();
        if (got.result_cluster !== want.result_cluster) begin
          errors++;
          $display("%0t: result_cluster mismatch, expected %h got %h",
                   $time, want.result_cluster, got.result_cluster);
        end
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d got %0d",
                   $time, want.status, got.status);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  fatcca_pkg::req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  fatcca_pkg::res_t res;
  logic cfg_we = 1'b0;
  logic [fatcca_pkg::CFG_W-1:0] cfg_data = '0;

  fat_chain_scoreboard sb;
  bit calm = 1'b0;
  int counted_reqs = 0;
  int quiet_cycles = 0;
  int n_settings = 1;

  fat12_cluster_chain_allocator #(
    .TABLE_ENTRIES(TBL_ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) sb.check_result(res);
      if ((req_valid && req_ready) || (res_valid && res_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [fatcca_pkg::CLUSTER_W-1:0] rand12();
    logic [31:0] w;
    w = $urandom;
    return w[fatcca_pkg::CLUSTER_W-1:0];
  endfunction

  function automatic logic [fatcca_pkg::CLUSTER_W-1:0] pick_cluster();
    logic [31:0] w;
    if ($urandom_range(0, 9) == 0) w = $urandom;
    else w = $urandom_range(0, sb.search_lim - 1);
    return w[fatcca_pkg::CLUSTER_W-1:0];
  endfunction

  task automatic send_req(input fatcca_pkg::req_t r, output fatcca_pkg::res_t want);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    want = sb.note_request(r);
    if (r.opcode <= fatcca_pkg::OP_WRITE_ENTRY) counted_reqs++;
  endtask

  task automatic send_op(input logic [fatcca_pkg::OPCODE_W-1:0] op,
                         input logic [fatcca_pkg::CLUSTER_W-1:0] cl,
                         input logic [fatcca_pkg::CLUSTER_W-1:0] val,
                         output fatcca_pkg::res_t want);
    fatcca_pkg::req_t r;
    r.opcode = op;
    r.cluster = cl;
    r.entry_value = val;
    send_req(r, want);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_valid_entries(input logic [fatcca_pkg::CFG_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_valid_entries(v);
    n_settings++;
  endtask

  task automatic build_chain();
    fatcca_pkg::res_t want;
    logic [fatcca_pkg::CLUSTER_W-1:0] head;
    logic [fatcca_pkg::CLUSTER_W-1:0] cur;
    int steps;
    int k;
    head = pick_cluster();
    cur = head;
    steps = $urandom_range(1, 6);
    for (k = 0; k < steps; k++) begin
      send_op(fatcca_pkg::OP_CHAIN_STEP, cur, rand12(), want);
      if (want.status == ST_NO_FREE) k = steps;
      else cur = want.result_cluster;
    end
    send_op(fatcca_pkg::OP_CHAIN_END, cur, rand12(), want);
    if ($urandom_range(0, 2) == 0) send_op(fatcca_pkg::OP_READ_ENTRY, head, rand12(), want);
  endtask

  task automatic random_phase(input int n_items);
    fatcca_pkg::res_t want;
    logic [31:0] w;
    int goal;
    int kind;
    goal = counted_reqs + n_items;
    while (counted_reqs < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        build_chain();
      end else if (kind < 70) begin
        send_op(fatcca_pkg::OP_FIND_FREE, pick_cluster(), rand12(), want);
      end else if (kind < 80) begin
        send_op(fatcca_pkg::OP_READ_ENTRY, pick_cluster(), rand12(), want);
      end else if (kind < 92) begin
        send_op(fatcca_pkg::OP_WRITE_ENTRY, pick_cluster(),
                ($urandom_range(0, 2) == 0) ? '0 : rand12(), want);
      end else if (kind < 96) begin
        send_op(fatcca_pkg::OP_CHAIN_END, pick_cluster(), rand12(), want);
      end else begin
        w = $urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST);
        send_op(w[fatcca_pkg::OPCODE_W-1:0], rand12(), rand12(), want);
      end
    end
  endtask

  initial begin : main_seq
    fatcca_pkg::res_t want;
    logic [31:0] w;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_op(fatcca_pkg::OP_READ_ENTRY, 12'd0, 12'd0, want);
    send_op(fatcca_pkg::OP_READ_ENTRY, 12'hFFF, 12'hFFF, want);
    send_op(fatcca_pkg::OP_FIND_FREE, 12'd0, 12'd0, want);
    send_op(fatcca_pkg::OP_FIND_FREE, 12'd2847, 12'd0, want);
    send_op(fatcca_pkg::OP_FIND_FREE, 12'd2848, 12'd0, want);
    send_op(fatcca_pkg::OP_FIND_FREE, 12'hFFF, 12'hFFF, want);
    send_op(fatcca_pkg::OP_CHAIN_STEP, 12'd2, 12'd0, want);
    send_op(fatcca_pkg::OP_CHAIN_STEP, 12'd3, 12'd0, want);
    send_op(fatcca_pkg::OP_CHAIN_END, 12'd4, 12'd0, want);
    send_op(fatcca_pkg::OP_READ_ENTRY, 12'd2, 12'd0, want);
    send_op(fatcca_pkg::OP_FIND_FREE, 12'd1, 12'd0, want);
    send_op(fatcca_pkg::OP_CHAIN_STEP, 12'hFFF, 12'd0, want);
    send_op(fatcca_pkg::OP_WRITE_ENTRY, 12'hFFF, 12'hFFF, want);
    send_op(fatcca_pkg::OP_READ_ENTRY, 12'hFFF, 12'd0, want);
    send_op(fatcca_pkg::OP_WRITE_ENTRY, 12'd1, 12'h5A5, want);
    send_op(OP_UNUSED_FIRST, 12'hFFF, 12'hFFF, want);
    send_op(OP_UNUSED_FIRST + 3'd1, 12'h000, 12'h000, want);
    send_op(OP_UNUSED_LAST, 12'hA5A, 12'h5A5, want);

    write_valid_entries(13'd3);
    send_op(fatcca_pkg::OP_FIND_FREE, 12'd0, 12'd0, want);
    send_op(fatcca_pkg::OP_WRITE_ENTRY, 12'd1, 12'd0, want);
    send_op(fatcca_pkg::OP_CHAIN_STEP, 12'd0, 12'd0, want);
    send_op(fatcca_pkg::OP_FIND_FREE, 12'd1, 12'd0, want);

    write_valid_entries(13'd4096);
    send_op(fatcca_pkg::OP_FIND_FREE, 12'd4094, 12'd0, want);
    send_op(fatcca_pkg::OP_WRITE_ENTRY, 12'hFFF, 12'd0, want);
    send_op(fatcca_pkg::OP_FIND_FREE, 12'd4094, 12'd0, want);

    write_valid_entries(13'd40);
    random_phase(12);
    wait_drained();
    random_phase(12);

    calm = 1'b1;
    write_valid_entries(13'd4096);
    random_phase(22);
    calm = 1'b0;

    w = $urandom_range(3, TBL_ENTRIES);
    write_valid_entries(w[fatcca_pkg::CFG_W-1:0]);
    random_phase(25);

    write_valid_entries(13'd3);
    random_phase(10);

    write_valid_entries(fatcca_pkg::VALID_ENTRIES_RESET);
    random_phase(18);

    wait_drained();
    repeat (16) @(posedge clk);

    $display("Sent %0d requests: %0d find free, %0d chain step, %0d chain end,",
             counted_reqs, sb.op_seen[fatcca_pkg::OP_FIND_FREE],
             sb.op_seen[fatcca_pkg::OP_CHAIN_STEP], sb.op_seen[fatcca_pkg::OP_CHAIN_END]);
    $display("%0d read, %0d write; %0d results checked, %0d failed scans, %0d table sizes.",
             sb.op_seen[fatcca_pkg::OP_READ_ENTRY], sb.op_seen[fatcca_pkg::OP_WRITE_ENTRY],
             sb.results_seen, sb.failed_scans, n_settings);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/fatcca_pkg.sv
hw/rtl/fatcca_ram.sv
hw/rtl/fatcca_dp.sv
hw/rtl/fatcca_ctrl.sv
hw/rtl/fat12_cluster_chain_allocator.sv
hw/rtl/fatcca_checker.sv
tb/fat12_cluster_chain_allocator_tb.sv
